// ===== design/lcef_pkg.sv =====
// ----------------------------------------------------------------------------
// lcef_pkg
// Shared types and constants of the lepton count event filter: field widths,
// register indexes, identification cut limits and the structs that travel
// between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package lcef_pkg;

   // Field widths
   localparam int DELTA_WIDTH   = 17;
   localparam int HOE_WIDTH     = 18;
   localparam int SHOWER_WIDTH  = 14;
   localparam int PT_WIDTH      = 16;
   localparam int COUNT_WIDTH   = 8;
   localparam int CSR_IDX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 16;

   // Queue between front and back end
   localparam int QUEUE_DEPTH = 4;

   // Register indexes of the control port
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ELECTRON_ID_ENABLE = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MUON_ID_ENABLE     = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_PT_LOW_THRESHOLD   = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_PT_HIGH_THRESHOLD  = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MIN_LOW_COUNT      = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MIN_HIGH_COUNT     = 3'd5;

   // Register reset values
   localparam logic [PT_WIDTH-1:0]    PT_LOW_RESET    = 16'd80;
   localparam logic [PT_WIDTH-1:0]    PT_HIGH_RESET   = 16'd160;
   localparam logic [COUNT_WIDTH-1:0] MIN_LOW_RESET   = 8'd1;
   localparam logic [COUNT_WIDTH-1:0] MIN_HIGH_RESET  = 8'd1;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX       = 8'd255;

   // Identification cut limits, 2^-14 units; a value above the limit fails
   localparam logic [DELTA_WIDTH-1:0]  BARREL_DETA   = 17'd115;
   localparam logic [DELTA_WIDTH-1:0]  BARREL_DPHI   = 17'd1311;
   localparam logic [HOE_WIDTH-1:0]    BARREL_HOE    = 18'd2458;
   localparam logic [SHOWER_WIDTH-1:0] BARREL_SHOWER = 14'd164;
   localparam logic [DELTA_WIDTH-1:0]  ENDCAP_DETA   = 17'd164;
   localparam logic [DELTA_WIDTH-1:0]  ENDCAP_DPHI   = 17'd1147;
   localparam logic [HOE_WIDTH-1:0]    ENDCAP_HOE    = 18'd1147;
   localparam logic [SHOWER_WIDTH-1:0] ENDCAP_SHOWER = 14'd492;

   // Control register set
   typedef struct packed {
      logic                   electron_id_enable;
      logic                   muon_id_enable;
      logic [PT_WIDTH-1:0]    pt_low_threshold;
      logic [PT_WIDTH-1:0]    pt_high_threshold;
      logic [COUNT_WIDTH-1:0] min_low_count;
      logic [COUNT_WIDTH-1:0] min_high_count;
   } cfg_type;

   // Classified item handed from front to back end
   typedef struct packed {
      logic inc_low;
      logic inc_high;
      logic last;
   } class_type;

endpackage

`default_nettype wire

// ===== design/lcef_if.sv =====
// ----------------------------------------------------------------------------
// lcef_req_if / lcef_rsp_if
// Valid/ready channels of the filter: one lepton item in, one event
// decision out.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcef_req_if;
   logic        valid;
   logic        ready;
   logic        carries_object;
   logic        is_muon;
   logic        in_barrel;
   logic        in_endcap;
   logic signed [16:0] delta_eta;
   logic signed [16:0] delta_phi;
   logic [17:0] hadronic_over_em;
   logic [13:0] shower_width;
   logic [15:0] pt;
   logic        is_global;
   logic        last_in_event;

   modport source (
      output valid, carries_object, is_muon, in_barrel, in_endcap, delta_eta,
             delta_phi, hadronic_over_em, shower_width, pt, is_global,
             last_in_event,
      input  ready
   );
   modport sink (
      input  valid, carries_object, is_muon, in_barrel, in_endcap, delta_eta,
             delta_phi, hadronic_over_em, shower_width, pt, is_global,
             last_in_event,
      output ready
   );
endinterface

interface lcef_rsp_if;
   logic       valid;
   logic       ready;
   logic       event_pass;
   logic [7:0] low_count;
   logic [7:0] high_count;

   modport source (
      output valid, event_pass, low_count, high_count,
      input  ready
   );
   modport sink (
      input  valid, event_pass, low_count, high_count,
      output ready
   );
endinterface

`default_nettype wire

// ===== design/lepton_count_event_filter_core.sv =====
// ----------------------------------------------------------------------------
// lepton_count_event_filter_core
// Counts identified leptons above two pt thresholds per event and gives one
// pass/fail decision with both counts on each event-closing item.
//
//   channel | direction | handshake       | contents
//   --------+-----------+-----------------+-------------------------------
//   req_bus | in        | valid/ready     | one lepton or end marker
//   rsp_bus | out       | valid/ready     | event_pass, low/high count
//   csr_*   | in        | write enable    | six control registers
//
// One item per cycle sustained while the queue and output register do not stall;
// an event result appears in the cycle after its closing item leaves the queue.
// Rate is set by the counter update in the back end.
// The front end stalls only when the queue is full; the back end stalls on
// an event end while the output register holds an untaken result.
// Reset is synchronous, clears counters and queue and loads the register reset values; no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module lepton_count_event_filter_core #(
   parameter int QueueDepth = lcef_pkg::QUEUE_DEPTH
) (
   input  wire                                  clock,
   input  wire                                  reset,
   lcef_req_if.sink                             req_bus,
   lcef_rsp_if.source                           rsp_bus,
   input  wire                                  csr_we,
   input  wire [lcef_pkg::CSR_IDX_WIDTH-1:0]    csr_index,
   input  wire [lcef_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   import lcef_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   class_type front_cls;
   class_type q_data;
   logic      q_full;
   logic      q_not_empty;
   logic      q_pop;
   logic      push;

   // Control register writes; unknown indexes are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ELECTRON_ID_ENABLE: cfg_in.electron_id_enable = csr_wdata[0];
            CSR_MUON_ID_ENABLE:     cfg_in.muon_id_enable     = csr_wdata[0];
            CSR_PT_LOW_THRESHOLD:   cfg_in.pt_low_threshold   = csr_wdata;
            CSR_PT_HIGH_THRESHOLD:  cfg_in.pt_high_threshold  = csr_wdata;
            CSR_MIN_LOW_COUNT:      cfg_in.min_low_count  = csr_wdata[COUNT_WIDTH-1:0];
            CSR_MIN_HIGH_COUNT:     cfg_in.min_high_count = csr_wdata[COUNT_WIDTH-1:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.electron_id_enable <= 1'b1;
         cfg_ff.muon_id_enable     <= 1'b1;
         cfg_ff.pt_low_threshold   <= PT_LOW_RESET;
         cfg_ff.pt_high_threshold  <= PT_HIGH_RESET;
         cfg_ff.min_low_count      <= MIN_LOW_RESET;
         cfg_ff.min_high_count     <= MIN_HIGH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Accept an item whenever the queue has room
   assign req_bus.ready = !q_full;
   assign push          = req_bus.valid && !q_full;

   lcef_front u_front (
      .cfg (cfg_ff),
      .req (req_bus),
      .cls (front_cls)
   );

   lcef_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_cls),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (q_data)
   );

   lcef_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_not_empty (q_not_empty),
      .q_data      (q_data),
      .q_pop       (q_pop),
      .rsp         (rsp_bus)
   );

endmodule

`default_nettype wire

// ===== design/lcef_front.sv =====
// ----------------------------------------------------------------------------
// lcef_front
// Front end: applies the electron and muon identification cuts and the two
// pt thresholds to one item and reduces it to counter increments.
// Purely combinational; the queue registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module lcef_front (
   input  wire lcef_pkg::cfg_type   cfg,
   lcef_req_if.sink                 req,
   output lcef_pkg::class_type      cls
);
   import lcef_pkg::*;

   logic [DELTA_WIDTH-1:0] deta_mag;
   logic [DELTA_WIDTH-1:0] dphi_mag;
   logic                   barrel_ok;
   logic                   endcap_ok;
   logic                   lepton_ok;

   // Magnitudes of the signed track-match deltas (most negative fits unsigned)
   assign deta_mag = req.delta_eta[DELTA_WIDTH-1] ? (~req.delta_eta + 1'b1)
                                                  : req.delta_eta;
   assign dphi_mag = req.delta_phi[DELTA_WIDTH-1] ? (~req.delta_phi + 1'b1)
                                                  : req.delta_phi;

   // Barrel and endcap cut sets, evaluated in parallel
   assign barrel_ok = (deta_mag <= BARREL_DETA) && (dphi_mag <= BARREL_DPHI) &&
                      (req.hadronic_over_em <= BARREL_HOE) &&
                      (req.shower_width <= BARREL_SHOWER);
   assign endcap_ok = (deta_mag <= ENDCAP_DETA) && (dphi_mag <= ENDCAP_DPHI) &&
                      (req.hadronic_over_em <= ENDCAP_HOE) &&
                      (req.shower_width <= ENDCAP_SHOWER);

   // Identification decision per lepton type
   always_comb begin
      if (req.is_muon) begin
         lepton_ok = !cfg.muon_id_enable || req.is_global;
      end else if (cfg.electron_id_enable) begin
         lepton_ok = (!req.in_barrel || barrel_ok) && (!req.in_endcap || endcap_ok);
      end else begin
         lepton_ok = 1'b1;
      end
   end

   // Counter increments; marker items carry only the event end
   assign cls.inc_low  = req.carries_object && lepton_ok &&
                         (req.pt > cfg.pt_low_threshold);
   assign cls.inc_high = req.carries_object && lepton_ok &&
                         (req.pt > cfg.pt_high_threshold);
   assign cls.last     = req.last_in_event;

endmodule

`default_nettype wire

// ===== design/lcef_queue.sv =====
// ----------------------------------------------------------------------------
// lcef_queue
// Small FIFO of classified items between the front and back end, so that
// either side can stall on its own. Push and pop may share a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lcef_queue #(
   parameter int Depth = lcef_pkg::QUEUE_DEPTH
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  wire lcef_pkg::class_type push_data,
   output logic                 full,
   input  wire                  pop,
   output logic                 not_empty,
   output lcef_pkg::class_type  pop_data
);
   import lcef_pkg::*;

   localparam int PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0]   PtrLast  = PtrWidth'(Depth - 1);
   localparam logic [CountWidth-1:0] CountTop = CountWidth'(Depth);

   class_type              entry_ff [Depth];
   logic [PtrWidth-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]  count_ff, count_in;

   assign full      = (count_ff == CountTop);
   assign not_empty = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   // Pointer wrap and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Fill count never passes the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountTop)
      else $error("queue fill count above depth");

   // Pop only from a non-empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue popped while empty");

   // Pointers agree with the fill count when empty or full
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == CountTop) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with fill count");

endmodule

`default_nettype wire

// ===== design/lcef_back.sv =====
// ----------------------------------------------------------------------------
// lcef_back
// Back end: applies queued increments to the two saturating lepton
// counters, and on the event end loads the decision into the output
// register and clears the counters.
// ----------------------------------------------------------------------------
`default_nettype none

module lcef_back (
   input  wire                  clock,
   input  wire                  reset,
   input  wire lcef_pkg::cfg_type cfg,
   input  wire                  q_not_empty,
   input  wire lcef_pkg::class_type q_data,
   output logic                 q_pop,
   lcef_rsp_if.source           rsp
);
   import lcef_pkg::*;

   logic [COUNT_WIDTH-1:0] low_ff, low_in;
   logic [COUNT_WIDTH-1:0] high_ff, high_in;
   logic [COUNT_WIDTH-1:0] low_sum;
   logic [COUNT_WIDTH-1:0] high_sum;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   pass_ff, pass_in;
   logic [COUNT_WIDTH-1:0] low_out_ff, low_out_in;
   logic [COUNT_WIDTH-1:0] high_out_ff, high_out_in;
   logic                   out_free;
   logic                   load_out;

   // Output register can take a result this cycle
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign q_pop    = q_not_empty && (!q_data.last || out_free);
   assign load_out = q_pop && q_data.last;

   // Saturating increments
   assign low_sum  = (q_data.inc_low && low_ff != COUNT_MAX) ? low_ff + 1'b1 : low_ff;
   assign high_sum = (q_data.inc_high && high_ff != COUNT_MAX) ? high_ff + 1'b1
                                                               : high_ff;

   // Counter and output register next values
   always_comb begin
      low_in       = low_ff;
      high_in      = high_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      pass_in      = pass_ff;
      low_out_in   = low_out_ff;
      high_out_in  = high_out_ff;
      if (load_out) begin
         low_in       = '0;
         high_in      = '0;
         rsp_valid_in = 1'b1;
         pass_in      = (low_sum >= cfg.min_low_count) &&
                        (high_sum >= cfg.min_high_count);
         low_out_in   = low_sum;
         high_out_in  = high_sum;
      end else if (q_pop) begin
         low_in  = low_sum;
         high_in = high_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff       <= '0;
         high_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         low_ff       <= low_in;
         high_ff      <= high_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload, no reset needed
   always_ff @(posedge clock) begin
      pass_ff     <= pass_in;
      low_out_ff  <= low_out_in;
      high_out_ff <= high_out_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.event_pass = pass_ff;
   assign rsp.low_count  = low_out_ff;
   assign rsp.high_count = high_out_ff;

   // Event end clears both counters
   a_clear_on_last: assert property (@(posedge clock) disable iff (reset)
      load_out |=> (low_ff == '0 && high_ff == '0))
      else $error("counters not cleared after event end");

   // Event end always presents a result next cycle
   a_result_on_last: assert property (@(posedge clock) disable iff (reset)
      load_out |=> rsp_valid_ff)
      else $error("event end gave no result");

   // An event end never overwrites a result still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready) |-> !load_out)
      else $error("pending result overwritten");

   // Counters hold when nothing is popped
   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !q_pop |=> ($stable(low_ff) && $stable(high_ff)))
      else $error("counters moved without a queued item");

endmodule

`default_nettype wire

// ===== test/lepton_count_event_filter_core_tb.sv =====
// ----------------------------------------------------------------------------
// lepton_count_event_filter_core_tb
// Self-checking bench for the lepton count event filter. A scoreboard class
// keeps its own copy of the control registers and the two saturating lepton
// counters, predicts one decision per event-closing transfer and compares
// every decision the block hands out. Stimulus is a short directed list at
// reset values, then random events under several register settings,
// including the extremes, a counter saturation event and a long output hold.
// ----------------------------------------------------------------------------
`default_nettype none

module lepton_count_event_filter_core_tb;
   import lcef_pkg::*;

   localparam int HALF_PERIOD      = 10;
   localparam int SETTLE_CYCLES    = 12;
   localparam int LONG_HOLD_CYCLES = 150;
   localparam int PHASE_ITEMS      = 175;
   localparam int RANDOM_PHASES    = 4;
   localparam int SATURATION_ITEMS = 270;
   localparam int WATCHDOG_TIME    = 20_000_000;

   // Register indexes the block does not decode
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SPARE_LOW  = 3'd6;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SPARE_HIGH = 3'd7;

   typedef struct packed {
      logic                          carries_object;
      logic                          is_muon;
      logic                          in_barrel;
      logic                          in_endcap;
      logic signed [DELTA_WIDTH-1:0] delta_eta;
      logic signed [DELTA_WIDTH-1:0] delta_phi;
      logic [HOE_WIDTH-1:0]          hadronic_over_em;
      logic [SHOWER_WIDTH-1:0]       shower_width;
      logic [PT_WIDTH-1:0]           pt;
      logic                          is_global;
      logic                          last_in_event;
   } lepton_item_type;

   typedef struct packed {
      logic                   event_pass;
      logic [COUNT_WIDTH-1:0] low_count;
      logic [COUNT_WIDTH-1:0] high_count;
   } event_decision_type;

   // Predicts event decisions and checks them in order
   class event_decision_board;
      cfg_type                cfg;
      logic [COUNT_WIDTH-1:0] low_cnt;
      logic [COUNT_WIDTH-1:0] high_cnt;
      event_decision_type     pending_decisions[$];
      int                     mismatches;
      int                     decided;
      int                     passed;

      function new();
         cfg = cfg_type'{1'b1, 1'b1, PT_LOW_RESET, PT_HIGH_RESET,
                         MIN_LOW_RESET, MIN_HIGH_RESET};
         low_cnt    = '0;
         high_cnt   = '0;
         mismatches = 0;
         decided    = 0;
         passed     = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_WIDTH-1:0] idx,
                              logic [CSR_DATA_WIDTH-1:0] data);
         case (idx)
            CSR_ELECTRON_ID_ENABLE: cfg.electron_id_enable = data[0];
            CSR_MUON_ID_ENABLE:     cfg.muon_id_enable     = data[0];
            CSR_PT_LOW_THRESHOLD:   cfg.pt_low_threshold   = data[PT_WIDTH-1:0];
            CSR_PT_HIGH_THRESHOLD:  cfg.pt_high_threshold  = data[PT_WIDTH-1:0];
            CSR_MIN_LOW_COUNT:      cfg.min_low_count      = data[COUNT_WIDTH-1:0];
            CSR_MIN_HIGH_COUNT:     cfg.min_high_count     = data[COUNT_WIDTH-1:0];
            default: ;
         endcase
      endfunction

      // |v| of a 17-bit two's complement value; -65536 gives 65536
      function logic [DELTA_WIDTH-1:0] magnitude(logic signed [DELTA_WIDTH-1:0] v);
         return v[DELTA_WIDTH-1] ? (~v + 1'b1) : v;
      endfunction

      function bit within_cuts(lepton_item_type it, logic [DELTA_WIDTH-1:0] lim_deta,
                               logic [DELTA_WIDTH-1:0] lim_dphi,
                               logic [HOE_WIDTH-1:0] lim_hoe,
                               logic [SHOWER_WIDTH-1:0] lim_sw);
         return !(magnitude(it.delta_eta) > lim_deta ||
                  magnitude(it.delta_phi) > lim_dphi ||
                  it.hadronic_over_em > lim_hoe || it.shower_width > lim_sw);
      endfunction

      function void note_lepton(lepton_item_type it);
         bit                 accepted;
         event_decision_type d;
         accepted = 1'b1;
         if (it.carries_object) begin
            if (it.is_muon) begin
               if (cfg.muon_id_enable && !it.is_global) accepted = 1'b0;
            end else if (cfg.electron_id_enable) begin
               if (it.in_barrel && !within_cuts(it, BARREL_DETA, BARREL_DPHI,
                                                BARREL_HOE, BARREL_SHOWER))
                  accepted = 1'b0;
               if (it.in_endcap && !within_cuts(it, ENDCAP_DETA, ENDCAP_DPHI,
                                                ENDCAP_HOE, ENDCAP_SHOWER))
                  accepted = 1'b0;
            end
            // counters stick at their maximum
            if (accepted && it.pt > cfg.pt_low_threshold && low_cnt != COUNT_MAX)
               low_cnt = low_cnt + 1'b1;
            if (accepted && it.pt > cfg.pt_high_threshold && high_cnt != COUNT_MAX)
               high_cnt = high_cnt + 1'b1;
         end
         if (it.last_in_event) begin
            d.event_pass = (low_cnt >= cfg.min_low_count) &&
                           (high_cnt >= cfg.min_high_count);
            d.low_count  = low_cnt;
            d.high_count = high_cnt;
            pending_decisions.push_back(d);
            low_cnt  = '0;
            high_cnt = '0;
         end
      endfunction

      function void check_decision(logic pass, logic [COUNT_WIDTH-1:0] lo,
                                   logic [COUNT_WIDTH-1:0] hi);
         event_decision_type want;
         if (pending_decisions.size() == 0) begin
            mismatches++;
            $display("%0t: decision with none expected: pass %0b low %0d high %0d",
                     $time, pass, lo, hi);
            return;
         end
         want = pending_decisions.pop_front();
         decided++;
         if (want.event_pass) passed++;
         if (pass !== want.event_pass) begin
            mismatches++;
            $display("%0t: event_pass expected %0b actual %0b",
                     $time, want.event_pass, pass);
         end
         if (lo !== want.low_count) begin
            mismatches++;
            $display("%0t: low_count expected %0d actual %0d",
                     $time, want.low_count, lo);
         end
         if (hi !== want.high_count) begin
            mismatches++;
            $display("%0t: high_count expected %0d actual %0d",
                     $time, want.high_count, hi);
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      csr_we;
   logic [CSR_IDX_WIDTH-1:0]  csr_index;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata;

   lcef_req_if req_bus ();
   lcef_rsp_if rsp_bus ();

   lepton_count_event_filter_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   event_decision_board board = new();
   int items_sent       = 0;
   int settings_applied = 0;
   bit steady           = 1'b0;   // no gaps on either side while set
   bit hold_request     = 1'b0;   // asks the receiver for one long hold

   // Clock
   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   // Watchdog
   initial begin
      #WATCHDOG_TIME;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Gap length: mostly none or short, a few long
   function automatic int random_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Receiver: random ready, one long hold on request, checks each transfer
   initial begin : rsp_side
      int stall_left;
      int r;
      bit take;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready)
            board.check_decision(rsp_bus.event_pass, rsp_bus.low_count,
                                 rsp_bus.high_count);
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = LONG_HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            take = 1'b0;
         end else if (steady) begin
            take = 1'b1;
         end else begin
            r = $urandom_range(99);
            if (r < 65) begin
               take = 1'b1;
            end else begin
               take       = 1'b0;
               stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
            end
         end
         rsp_bus.ready <= take;
      end
   end

   // ---------------------------------------------------------------- sender
   task automatic drive_fields(lepton_item_type it);
      req_bus.carries_object   <= it.carries_object;
      req_bus.is_muon          <= it.is_muon;
      req_bus.in_barrel        <= it.in_barrel;
      req_bus.in_endcap        <= it.in_endcap;
      req_bus.delta_eta        <= it.delta_eta;
      req_bus.delta_phi        <= it.delta_phi;
      req_bus.hadronic_over_em <= it.hadronic_over_em;
      req_bus.shower_width     <= it.shower_width;
      req_bus.pt               <= it.pt;
      req_bus.is_global        <= it.is_global;
      req_bus.last_in_event    <= it.last_in_event;
   endtask

   task automatic send_item(lepton_item_type it);
      drive_fields(it);
      req_bus.valid <= 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      board.note_lepton(it);
      items_sent++;
   endtask

   task automatic pause_sender(int n);
      if (n > 0) begin
         req_bus.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_with_gap(lepton_item_type it);
      send_item(it);
      pause_sender(random_gap());
   endtask

   // Sender stops until every decision is in, then lets the queue settle
   task automatic wait_all_decided();
      req_bus.valid <= 1'b0;
      while (board.pending_decisions.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------- registers
   task automatic csr_write(logic [CSR_IDX_WIDTH-1:0] idx,
                            logic [CSR_DATA_WIDTH-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      board.write_reg(idx, data);
   endtask

   // Narrow registers get junk in the unused upper bits
   task automatic apply_settings(cfg_type c);
      logic [CSR_DATA_WIDTH-1:0] junk;
      junk = CSR_DATA_WIDTH'($urandom);
      csr_write(CSR_ELECTRON_ID_ENABLE, {junk[15:1], c.electron_id_enable});
      csr_write(CSR_MUON_ID_ENABLE, {~junk[15:1], c.muon_id_enable});
      csr_write(CSR_PT_LOW_THRESHOLD, c.pt_low_threshold);
      csr_write(CSR_PT_HIGH_THRESHOLD, c.pt_high_threshold);
      csr_write(CSR_MIN_LOW_COUNT, {junk[15:8], c.min_low_count});
      csr_write(CSR_MIN_HIGH_COUNT, {~junk[15:8], c.min_high_count});
      csr_write(CSR_SPARE_LOW, junk);
      csr_write(CSR_SPARE_HIGH, ~junk);
      csr_we <= 1'b0;
      settings_applied++;
   endtask

   function automatic logic [PT_WIDTH-1:0] pick_threshold();
      int r;
      r = $urandom_range(99);
      if (r < 50) return PT_WIDTH'($urandom_range(0, 400));
      if (r < 75) return PT_WIDTH'($urandom);
      return $urandom_range(1) ? '1 : '0;
   endfunction

   function automatic logic [COUNT_WIDTH-1:0] pick_minimum();
      int r;
      r = $urandom_range(99);
      if (r < 75) return COUNT_WIDTH'($urandom_range(0, 3));
      if (r < 90) return '0;
      return COUNT_MAX;
   endfunction

   function automatic cfg_type random_settings();
      cfg_type c;
      c.electron_id_enable = 1'($urandom_range(1));
      c.muon_id_enable     = 1'($urandom_range(1));
      c.pt_low_threshold   = pick_threshold();
      c.pt_high_threshold  = pick_threshold();
      c.min_low_count      = pick_minimum();
      c.min_high_count     = pick_minimum();
      return c;
   endfunction

   // ------------------------------------------------------------ item makers
   function automatic lepton_item_type make_electron(bit barrel, bit endcap, int deta,
                                                     int dphi, int hoe, int sw,
                                                     int pt, bit last);
      lepton_item_type it;
      it                  = '0;
      it.carries_object   = 1'b1;
      it.in_barrel        = barrel;
      it.in_endcap        = endcap;
      it.delta_eta        = 17'(deta);
      it.delta_phi        = 17'(dphi);
      it.hadronic_over_em = 18'(hoe);
      it.shower_width     = 14'(sw);
      it.pt               = 16'(pt);
      it.is_global        = 1'($urandom_range(1));
      it.last_in_event    = last;
      return it;
   endfunction

   // Muon with junk in the electron-only fields
   function automatic lepton_item_type make_muon(bit global_muon, int pt, bit last);
      lepton_item_type it;
      logic [95:0]     noise;
      noise             = {$urandom, $urandom, $urandom};
      it                = noise[$bits(lepton_item_type)-1:0];
      it.carries_object = 1'b1;
      it.is_muon        = 1'b1;
      it.is_global      = global_muon;
      it.pt             = 16'(pt);
      it.last_in_event  = last;
      return it;
   endfunction

   // Marker: lepton fields are random and must be ignored
   function automatic lepton_item_type noise_marker(bit last);
      lepton_item_type it;
      logic [95:0]     noise;
      noise             = {$urandom, $urandom, $urandom};
      it                = noise[$bits(lepton_item_type)-1:0];
      it.carries_object = 1'b0;
      it.last_in_event  = last;
      return it;
   endfunction

   // Shower/track value: mostly passing, often on a cut edge, sometimes anything
   function automatic logic [17:0] pick_cut_value(int tight, int loose, bit signed_field);
      int r;
      int v;
      r = $urandom_range(99);
      if (r < 55) begin
         v = $urandom_range(0, tight);
      end else if (r < 80) begin
         case ($urandom_range(3))
            0:       v = tight;
            1:       v = tight + 1;
            2:       v = loose;
            default: v = loose + 1;
         endcase
      end else begin
         return 18'($urandom);
      end
      if (signed_field && $urandom_range(1)) v = -v;
      return 18'(v);
   endfunction

   // Pt around the current thresholds, plus extremes and anything
   function automatic logic [PT_WIDTH-1:0] pick_pt();
      int r;
      r = $urandom_range(99);
      if (r < 30) return board.cfg.pt_low_threshold + 16'($urandom_range(0, 2)) - 1'b1;
      if (r < 60) return board.cfg.pt_high_threshold + 16'($urandom_range(0, 2)) - 1'b1;
      if (r < 85) return PT_WIDTH'($urandom);
      return $urandom_range(1) ? '1 : '0;
   endfunction

   function automatic lepton_item_type random_lepton(bit last);
      lepton_item_type it;
      logic [17:0]     v;
      it                = '0;
      it.carries_object = 1'b1;
      it.is_muon        = ($urandom_range(99) < 40);
      it.in_barrel      = 1'($urandom_range(1));
      it.in_endcap      = 1'($urandom_range(1));
      v = pick_cut_value(int'(BARREL_DETA), int'(ENDCAP_DETA), 1'b1);
      it.delta_eta = v[DELTA_WIDTH-1:0];
      v = pick_cut_value(int'(ENDCAP_DPHI), int'(BARREL_DPHI), 1'b1);
      it.delta_phi = v[DELTA_WIDTH-1:0];
      v = pick_cut_value(int'(ENDCAP_HOE), int'(BARREL_HOE), 1'b0);
      it.hadronic_over_em = v;
      v = pick_cut_value(int'(BARREL_SHOWER), int'(ENDCAP_SHOWER), 1'b0);
      it.shower_width  = v[SHOWER_WIDTH-1:0];
      it.pt            = pick_pt();
      it.is_global     = ($urandom_range(99) < 75);
      it.last_in_event = last;
      return it;
   endfunction

   // One event: a few leptons, stray open markers, closed by a lepton or a marker
   task automatic send_random_event();
      int n;
      bit on_object;
      n         = ($urandom_range(99) < 10) ? 0 : $urandom_range(1, 6);
      on_object = (n > 0) && $urandom_range(1);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 8) send_with_gap(noise_marker(1'b0));
         send_with_gap(random_lepton(on_object && i == n - 1));
      end
      if (!on_object) send_with_gap(noise_marker(1'b1));
   endtask

   task automatic run_phase(cfg_type c, int items);
      int stop;
      wait_all_decided();
      apply_settings(c);
      stop = items_sent + items;
      while (items_sent < stop) send_random_event();
   endtask

   // Directed list at reset values: cut edges, regions, muon rules, markers
   task automatic run_directed();
      send_with_gap(noise_marker(1'b1));                                       // empty
      send_with_gap(make_electron(1'b1, 1'b0, 115, -1311, 2458, 164, 161, 1'b0)); // barrel
      send_with_gap(make_electron(1'b1, 1'b0, -116, 0, 0, 0, 65535, 1'b0));   // barrel deta
      send_with_gap(make_electron(1'b0, 1'b1, -164, 1147, 1147, 492, 81, 1'b0)); // endcap
      send_with_gap(make_electron(1'b0, 1'b1, 0, 0, 0, 493, 200, 1'b0));      // shower
      send_with_gap(make_electron(1'b1, 1'b1, 0, 0, 2000, 0, 200, 1'b0));     // both, H/E
      send_with_gap(make_electron(1'b1, 1'b1, 0, 0, 0, 0, 200, 1'b0));        // both, clean
      send_with_gap(make_electron(1'b0, 1'b0, -65536, 65535, 262143, 16383, 65535, 1'b0));
      send_with_gap(make_muon(1'b1, 80, 1'b0));                               // at low cut
      send_with_gap(make_muon(1'b0, 65535, 1'b0));                            // not global
      send_with_gap(make_muon(1'b1, 160, 1'b0));                              // at high cut
      send_with_gap(noise_marker(1'b0));
      send_with_gap(make_electron(1'b0, 1'b0, 0, 0, 0, 0, 0, 1'b1));
      send_with_gap(make_electron(1'b1, 1'b0, 0, 1312, 0, 0, 500, 1'b1));     // barrel dphi
      send_with_gap(make_muon(1'b1, 65535, 1'b1));
      send_with_gap(noise_marker(1'b1));
   endtask

   // ------------------------------------------------------------- main flow
   initial begin : stimulus
      reset     <= 1'b1;
      csr_we    <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_bus.valid <= 1'b0;
      drive_fields('0);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      // Fixed settings, extremes among them
      run_phase(cfg_type'{1'b1, 1'b1, 16'd80, 16'd160, 8'd1, 8'd1}, PHASE_ITEMS);
      run_phase(cfg_type'{1'b0, 1'b0, 16'd0, 16'd0, 8'd0, 8'd0}, PHASE_ITEMS);
      run_phase(cfg_type'{1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 8'd0, 8'd0}, PHASE_ITEMS);
      run_phase(cfg_type'{1'b0, 1'b1, 16'd0, 16'd1, COUNT_MAX, COUNT_MAX}, PHASE_ITEMS);

      // Both counters run into saturation within one event
      steady = 1'b1;
      for (int i = 0; i < SATURATION_ITEMS; i++)
         send_item(make_muon(1'b1, 65535, i == SATURATION_ITEMS - 1));
      steady = 1'b0;

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         run_phase(random_settings(), PHASE_ITEMS);
         if (p == 1) begin
            // output held back while closing items keep coming
            hold_request = 1'b1;
            for (int i = 0; i < 30; i++) send_item(random_lepton(1'b1));
         end
         if (p == 2) begin
            steady = 1'b1;
            for (int i = 0; i < 20; i++) send_random_event();
            steady = 1'b0;
         end
      end

      wait_all_decided();
      $display("Covered %0d transfers under %0d register settings.",
               items_sent, settings_applied);
      $display("Decided %0d events, %0d of them passing.", board.decided, board.passed);
      if (board.mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

`default_nettype wire
